@@ src/tscrw_pkg.sv @@
// Shared types, defaults and pixel packing functions for the cell row writer.
`default_nettype none
package tscrw_pkg;

	localparam int COLUMNS_DEF     = 64;
	localparam int CELL_HEIGHT_DEF = 12;
	localparam int ROW_BYTES_DEF   = 48;
	localparam int TEXT_ROWS_DEF   = 16;
	localparam int TEXT_ROWS_MAX   = 16;

	localparam logic [7:0] BLOCK_FLAG = 8'h80;

	typedef struct packed {
		logic [9:0] cell_address;
		logic [7:0] char_code;
		logic [3:0] glyph_row;
		logic [7:0] font_row_bits;
		logic       protected_cell;
	} cell_t;

	typedef struct packed {
		logic [13:0] byte_address;
		logic [15:0] write_data;
		logic [15:0] write_mask;
	} wr_t;

	function automatic logic [15:0] phase_mask(input logic [1:0] phase);
		logic [15:0] m;
		case (phase)
			2'd0: m = 16'h00fc;
			2'd1: m = 16'hf003;
			2'd2: m = 16'hc00f;
			default: m = 16'h003f;
		endcase
		return m;
	endfunction

	function automatic logic [15:0] text_bits(input logic [1:0] phase, input logic [7:0] f);
		logic [15:0] d;
		case (phase)
			2'd0: d = {8'h00, f[7:2], 2'b00};
			2'd1: d = {f[5:2], 10'h000, f[7:6]};
			2'd2: d = {f[3:2], 10'h000, f[7:4]};
			default: d = {10'h000, f[7:2]};
		endcase
		return d;
	endfunction

	function automatic logic [15:0] block_bits(input logic [1:0] phase, input logic [1:0] pair);
		logic [15:0] l;
		logic [15:0] r;
		case (phase)
			2'd0: begin l = 16'h00e0; r = 16'h001c; end
			2'd1: begin l = 16'h8003; r = 16'h7000; end
			2'd2: begin l = 16'h000e; r = 16'hc001; end
			default: begin l = 16'h0038; r = 16'h0007; end
		endcase
		return (pair[0] ? l : 16'h0000) | (pair[1] ? r : 16'h0000);
	endfunction

endpackage
`default_nettype wire

@@ src/text_semigraphics_cell_row_writer_top.sv @@
// Cell row writer: one glyph row of one cell to one masked frame-buffer write.
// The cell row is registered in the input register, and its write in the output register.
// Throughput: one cell row per cycle; a stalled write holds the input only once the
// input register also holds a row that writes, dropped rows never wait.
// Rows of protected or off-screen cells or past CELL_HEIGHT are dropped without a write.
// Reset clears the valid flags of both registers; payload is not reset.
`default_nettype none
module text_semigraphics_cell_row_writer_top #(
	parameter int COLUMNS     = tscrw_pkg::COLUMNS_DEF,
	parameter int CELL_HEIGHT = tscrw_pkg::CELL_HEIGHT_DEF,
	parameter int ROW_BYTES   = tscrw_pkg::ROW_BYTES_DEF,
	parameter int TEXT_ROWS   = tscrw_pkg::TEXT_ROWS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cell_valid,
	output logic                  cell_stall,
	input  wire tscrw_pkg::cell_t cell_row,
	output logic                  wr_valid,
	input  wire logic             wr_stall,
	output tscrw_pkg::wr_t        wr
);

	localparam logic [10:0] SCREEN_CELLS = 11'(TEXT_ROWS * COLUMNS);

	logic             vld_s1;
	tscrw_pkg::cell_t cell_s1;
	logic             vld_s2;
	tscrw_pkg::wr_t   wr_s2;

	logic [3:0]       crow;
	logic [10:0]      base;
	logic [5:0]       col;
	logic [1:0]       phase;
	logic [1:0]       inner;
	logic             ok;
	logic [15:0]      addr_full;
	logic [1:0]       pair;
	logic [15:0]      data;
	logic [15:0]      mask;
	logic             out_free;
	logic             s1_go;

	always_comb begin
		crow = 4'd0;
		base = 11'd0;
		for (int k = 1; k < tscrw_pkg::TEXT_ROWS_MAX; k++) begin
			if (k < TEXT_ROWS && {1'b0, cell_s1.cell_address} >= 11'(k * COLUMNS)) begin
				crow = 4'(k);
				base = 11'(k * COLUMNS);
			end
		end
	end

	assign col   = 6'({1'b0, cell_s1.cell_address} - base);
	assign phase = col[1:0];
	assign ok    = !cell_s1.protected_cell
		&& ({1'b0, cell_s1.cell_address} < SCREEN_CELLS)
		&& (32'(cell_s1.glyph_row) < CELL_HEIGHT);

	always_comb begin
		case (phase)
			2'd2: inner = 2'd1;
			2'd3: inner = 2'd2;
			default: inner = 2'd0;
		endcase
	end

	assign addr_full = (16'(crow) * 16'(CELL_HEIGHT) + 16'(cell_s1.glyph_row))
		* 16'(ROW_BYTES) + 16'(col[5:2]) * 16'd3 + 16'(inner);

	always_comb begin
		case (cell_s1.glyph_row[3:2])
			2'd0: pair = cell_s1.char_code[1:0];
			2'd1: pair = cell_s1.char_code[3:2];
			2'd2: pair = cell_s1.char_code[5:4];
			default: pair = 2'b00;
		endcase
	end

	assign mask = tscrw_pkg::phase_mask(phase);
	assign data = mask & (((cell_s1.char_code & tscrw_pkg::BLOCK_FLAG) == 8'h00)
		? tscrw_pkg::text_bits(phase, cell_s1.font_row_bits)
		: tscrw_pkg::block_bits(phase, pair));

	assign out_free   = !vld_s2 || !wr_stall;
	assign s1_go      = vld_s1 && (out_free || !ok);
	assign cell_stall = vld_s1 && ok && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || s1_go) begin
			vld_s1 <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!vld_s1 || s1_go) && cell_valid) begin
			cell_s1 <= cell_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= vld_s1 && ok;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s1 && ok) begin
			wr_s2.byte_address <= addr_full[13:0];
			wr_s2.write_data   <= data;
			wr_s2.write_mask   <= mask;
		end
	end

	assign wr_valid = vld_s2;
	assign wr       = wr_s2;

endmodule
`default_nettype wire

@@ src/tscrw_chk.sv @@
// Port checker for the cell row writer and its bind.
`default_nettype none
module tscrw_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cell_valid,
	input wire logic             cell_stall,
	input wire tscrw_pkg::cell_t cell_row,
	input wire logic             wr_valid,
	input wire logic             wr_stall,
	input wire tscrw_pkg::wr_t   wr
);

	a_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_stall |=> wr_valid && $stable(wr))
		else $error("stalled write transfer changed");

	a_data_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> (wr.write_data & ~wr.write_mask) == 16'h0000)
		else $error("write data outside mask");

	a_mask_form: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> wr.write_mask == 16'h00fc || wr.write_mask == 16'hf003
			|| wr.write_mask == 16'hc00f || wr.write_mask == 16'h003f)
		else $error("bad write mask");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> wr_valid && wr_stall)
		else $error("input stalled while output free");

	a_cell_seen: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_stall && !cell_row.protected_cell
			&& cell_row.cell_address == 10'd0 && cell_row.glyph_row == 4'd0
			&& !wr_stall ##1 !wr_stall |=> wr_valid)
		else $error("write lost for first cell row");

endmodule

bind text_semigraphics_cell_row_writer_top tscrw_chk u_tscrw_chk (.*);
`default_nettype wire

@@ tb/sv/text_semigraphics_cell_row_writer_top_test.sv @@
// Testbench for the cell row writer: directed rows, then random rows checked by a pixel predictor.
`timescale 1ns / 1ps
module text_semigraphics_cell_row_writer_top_test;

	localparam int COLUMNS     = tscrw_pkg::COLUMNS_DEF;
	localparam int CELL_HEIGHT = tscrw_pkg::CELL_HEIGHT_DEF;
	localparam int ROW_BYTES   = tscrw_pkg::ROW_BYTES_DEF;
	localparam int TEXT_ROWS   = tscrw_pkg::TEXT_ROWS_DEF;
	localparam int RANDOM_ITEMS  = 480;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 8;

	typedef enum logic [1:0] {BY_PREDICTOR, NO_WRITE, TYPED_WRITE} row_check_t;

	typedef struct {
		tscrw_pkg::cell_t item;
		row_check_t       check;
		tscrw_pkg::wr_t   typed;
	} cell_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cell_valid = 1'b0;
	logic             cell_stall;
	tscrw_pkg::cell_t cell_row = '0;
	logic             wr_valid;
	logic             wr_stall = 1'b0;
	tscrw_pkg::wr_t   wr;

	tscrw_pkg::wr_t pending_writes[$];
	cell_row_t      cell_rows[$];
	int             fail_count = 0;
	int             cycle_count = 0;
	int             stall_left = 0;
	bit             tx_steady = 1'b0;
	bit             rx_steady = 1'b0;

	text_semigraphics_cell_row_writer_top #(
		.COLUMNS(COLUMNS),
		.CELL_HEIGHT(CELL_HEIGHT),
		.ROW_BYTES(ROW_BYTES),
		.TEXT_ROWS(TEXT_ROWS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.cell_row(cell_row),
		.wr_valid(wr_valid),
		.wr_stall(wr_stall),
		.wr(wr)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Place each of the six pixels of the cell at its frame-buffer bit.
	function automatic bit predict_write(input tscrw_pkg::cell_t c, output tscrw_pkg::wr_t w);
		int col;
		int crow;
		int phase;
		int first_byte;
		int sel;
		int g;
		int pos;
		int addr;
		logic [5:0] lit;
		logic [1:0] pair;
		w = '0;
		if (c.protected_cell)
			return 1'b0;
		col = c.cell_address % COLUMNS;
		crow = c.cell_address / COLUMNS;
		if (crow >= TEXT_ROWS || c.glyph_row >= CELL_HEIGHT)
			return 1'b0;
		phase = col % 4;
		first_byte = phase * 6 / 8;
		if (c.char_code[7]) begin
			sel = c.glyph_row / 4;
			pair = (sel < 3) ? c.char_code[2 * sel +: 2] : 2'b00;
			lit = {{3{pair[1]}}, {3{pair[0]}}};
		end else begin
			for (int k = 0; k < 6; k++)
				lit[k] = c.font_row_bits[7 - k];
		end
		for (int k = 0; k < 6; k++) begin
			g = phase * 6 + k;
			pos = (g / 8 - first_byte) * 8 + 7 - g % 8;
			w.write_mask[pos] = 1'b1;
			w.write_data[pos] = lit[k];
		end
		addr = (crow * CELL_HEIGHT + c.glyph_row) * ROW_BYTES + (col / 4) * 3 + first_byte;
		w.byte_address = addr[13:0];
		return 1'b1;
	endfunction

	task automatic add_row(input logic [9:0] addr, input logic [7:0] code, input logic [3:0] grow,
			input logic [7:0] font, input logic prot, input row_check_t check,
			input logic [13:0] t_addr, input logic [15:0] t_data, input logic [15:0] t_mask);
		cell_row_t r;
		r.item = '{cell_address: addr, char_code: code, glyph_row: grow,
			font_row_bits: font, protected_cell: prot};
		r.check = check;
		r.typed = '{byte_address: t_addr, write_data: t_data, write_mask: t_mask};
		cell_rows.push_back(r);
	endtask

	task automatic send_cell(input tscrw_pkg::cell_t c, input bit has_write,
			input tscrw_pkg::wr_t w);
		int gap;
		gap = tx_steady ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 12));
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_row <= c;
		cell_valid <= 1'b1;
		@(posedge clk);
		while (cell_stall)
			@(posedge clk);
		if (has_write)
			pending_writes.push_back(w);
	endtask

	always @(posedge clk) begin
		tscrw_pkg::wr_t exp_wr;
		int n;
		if (wr_valid && !wr_stall) begin
			if (pending_writes.size() == 0) begin
				$error("write with none expected: byte_address %0h data %0h mask %0h",
					wr.byte_address, wr.write_data, wr.write_mask);
				fail_count++;
			end else begin
				exp_wr = pending_writes.pop_front();
				if (wr.byte_address !== exp_wr.byte_address) begin
					$error("byte_address: expected %0h, actual %0h",
						exp_wr.byte_address, wr.byte_address);
					fail_count++;
				end
				if (wr.write_data !== exp_wr.write_data) begin
					$error("write_data: expected %0h, actual %0h",
						exp_wr.write_data, wr.write_data);
					fail_count++;
				end
				if (wr.write_mask !== exp_wr.write_mask) begin
					$error("write_mask: expected %0h, actual %0h",
						exp_wr.write_mask, wr.write_mask);
					fail_count++;
				end
			end
			n = rx_steady ? 0 : $urandom_range(0, 12);
			stall_left <= n;
			wr_stall <= (n != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			wr_stall <= (stall_left > 1);
		end
	end

	initial begin
		tscrw_pkg::cell_t c;
		tscrw_pkg::wr_t w;
		bit has_write;
		int items_sent;
		int drain;

		add_row(10'd0, 8'h00, 4'd0, 8'hff, 1'b0, TYPED_WRITE, 14'd0, 16'h00fc, 16'h00fc);
		add_row(10'd1, 8'h00, 4'd0, 8'hff, 1'b0, TYPED_WRITE, 14'd0, 16'hf003, 16'hf003);
		add_row(10'd2, 8'h00, 4'd0, 8'hff, 1'b0, TYPED_WRITE, 14'd1, 16'hc00f, 16'hc00f);
		add_row(10'd3, 8'h00, 4'd0, 8'hff, 1'b0, TYPED_WRITE, 14'd2, 16'h003f, 16'h003f);
		add_row(10'd1023, 8'hff, 4'd11, 8'h00, 1'b0, TYPED_WRITE, 14'd9215, 16'h003f, 16'h003f);
		add_row(10'd0, 8'h00, 4'd0, 8'h03, 1'b0, TYPED_WRITE, 14'd0, 16'h0000, 16'h00fc);
		add_row(10'd0, 8'h80, 4'd0, 8'hff, 1'b0, TYPED_WRITE, 14'd0, 16'h0000, 16'h00fc);
		add_row(10'd5, 8'h41, 4'd3, 8'hff, 1'b1, NO_WRITE, '0, '0, '0);
		add_row(10'd1023, 8'h41, 4'd12, 8'hff, 1'b0, NO_WRITE, '0, '0, '0);
		add_row(10'd512, 8'hff, 4'd15, 8'hff, 1'b0, NO_WRITE, '0, '0, '0);
		add_row(10'd4, 8'h81, 4'd0, 8'h00, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd5, 8'h82, 4'd1, 8'hff, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd6, 8'h84, 4'd4, 8'h00, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd7, 8'hb0, 4'd8, 8'h00, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd65, 8'hbf, 4'd11, 8'h00, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd66, 8'h7f, 4'd5, 8'ha5, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd67, 8'h41, 4'd7, 8'h5a, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd512, 8'hc3, 4'd2, 8'hff, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd960, 8'h20, 4'd11, 8'hfc, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd63, 8'h7e, 4'd6, 8'h81, 1'b0, BY_PREDICTOR, '0, '0, '0);
		add_row(10'd1022, 8'haa, 4'd9, 8'h00, 1'b0, BY_PREDICTOR, '0, '0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (cell_rows[i]) begin
			case (cell_rows[i].check)
				TYPED_WRITE: begin
					has_write = 1'b1;
					w = cell_rows[i].typed;
				end
				NO_WRITE: begin
					has_write = 1'b0;
					w = '0;
				end
				default: has_write = predict_write(cell_rows[i].item, w);
			endcase
			send_cell(cell_rows[i].item, has_write, w);
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent % 40 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			c.cell_address = 10'($urandom_range(0, 1023));
			c.char_code = 8'($urandom_range(0, 255));
			c.font_row_bits = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 4) != 0) begin
				c.glyph_row = 4'($urandom_range(0, CELL_HEIGHT - 1));
				c.protected_cell = 1'b0;
			end else begin
				c.glyph_row = 4'($urandom_range(0, 15));
				c.protected_cell = 1'($urandom_range(0, 1));
			end
			has_write = predict_write(c, w);
			send_cell(c, has_write, w);
			items_sent++;
		end
		cell_valid <= 1'b0;

		while (pending_writes.size() != 0)
			@(posedge clk);
		drain = DRAIN_CYCLES;
		repeat (drain) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
